// ===== sv/multi_channel_heartbeat_watchdog_assert.svh =====
// ----------------------------------------------------------------------------
// heartbeat watchdog assertion macros
// shorthand for clocked assertions on clk_i, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_ASSERT_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_ASSERT_SVH

// checked only outside reset
`define MCHW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define MCHW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg
// shared constants, codes and types of the heartbeat watchdog
// ----------------------------------------------------------------------------
package mchw_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned MIN_LIMIT_MS  = 5000;
  localparam int unsigned LIMIT_RESET   = 25000;

  localparam int unsigned IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ID_W       = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SCNT_W     = 8;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEAT    = 3'd0,
    FUNC_REMOVE  = 3'd1,
    FUNC_SUSPEND = 3'd2,
    FUNC_RESUME  = 3'd3,
    FUNC_CHECK   = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HANG_LIMIT   = 1'b0,
    CFG_CHECK_ENABLE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] last_beat;
    logic [SCNT_W-1:0] susp_cnt;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             set_valid;
    logic             clr_valid;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } slot_req_t;

  typedef struct packed {
    slot_t                    rd_data;
    logic [TABLE_ENTRIES-1:0] valid;
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
  } slot_rsp_t;

endpackage

// ===== sv/mchw_if.sv =====
// ----------------------------------------------------------------------------
// mchw channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mchw_in_if;
  logic                          valid;
  logic                          ready;
  logic [mchw_pkg::FUNC_W-1:0]   func;
  logic [mchw_pkg::ID_W-1:0]     client_id;
  logic [mchw_pkg::TIME_W-1:0]   now_ms;
  logic                          check_inhibit;

  modport source (output valid, func, client_id, now_ms, check_inhibit, input ready);
  modport sink   (input valid, func, client_id, now_ms, check_inhibit, output ready);
endinterface

interface mchw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hang_found;
  logic [mchw_pkg::ID_W-1:0]     hung_id;
  logic [mchw_pkg::STATUS_W-1:0] status;

  modport source (output valid, hang_found, hung_id, status, input ready);
  modport sink   (input valid, hang_found, hung_id, status, output ready);
endinterface

// ===== sv/mchw_slot_mem.sv =====
// ----------------------------------------------------------------------------
// mchw_slot_mem
// slot table: synchronous memory with registered read, valid flags and
// lowest free slot search
// ----------------------------------------------------------------------------
module mchw_slot_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mchw_pkg::slot_req_t req_i,
  output mchw_pkg::slot_rsp_t rsp_o
);
  import mchw_pkg::*;

  slot_t                    mem_q [TABLE_ENTRIES];
  slot_t                    rd_data_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.set_valid) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end else if (req_i.clr_valid) begin
      valid_q[req_i.wr_addr] <= 1'b0;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign rsp_o.rd_data    = rd_data_q;
  assign rsp_o.valid      = valid_q;
  assign rsp_o.free_found = free_found;
  assign rsp_o.free_idx   = free_idx;

endmodule

// ===== sv/multi_channel_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog
// client table with heartbeat, remove, suspend, resume and hang check
//
//   channel  dir  fields                                   beat when
//   req_i    in   func, client_id, now_ms, check_inhibit   valid & ready
//   rsp_o    out  hang_found, hung_id, status              valid & ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                   cfg_we_i
//
// one request at a time; the slot memory is read one slot per cycle, and a
// request passes S_SCAN, S_WRITE and S_DONE, the scan ending early on a match;
// a skipped check or an unused code goes from S_IDLE straight to S_DONE
// reset clears the valid flags and the control state, no memory clearing
// a waiting response is held in the output register while the next request
// is accepted; a finished request waits only if that register is still full
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mchw_in_if.sink                            req_i,
  mchw_out_if.source                         rsp_o,
  input  logic                               cfg_we_i,
  input  logic [mchw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mchw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import mchw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [TIME_W-1:0]  limit_q, limit_d;
  logic               enable_q, enable_d;

  func_e              func_q, func_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [TIME_W-1:0]  now_q, now_d;

  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  slot_t              ent_q, ent_d;

  logic               res_found_q, res_found_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  status_e            res_status_q, res_status_d;

  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  status_e            out_status_q, out_status_d;

  slot_req_t          mreq;
  slot_rsp_t          mrsp;

  logic               accept;
  logic               armed;
  logic [TIME_W-1:0]  age;
  logic               hit_now;
  logic [TIME_W-1:0]  cfg_limit;

  mchw_slot_mem u_slot_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign armed       = (limit_q != '0) && enable_q && !req_i.check_inhibit;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hang_found = out_found_q;
  assign rsp_o.hung_id    = out_id_q;
  assign rsp_o.status     = out_status_q;

  assign age = now_q - mrsp.rd_data.last_beat;

  always_comb begin
    if (func_q == FUNC_CHECK) begin
      hit_now = mrsp.valid[cmp_idx_q] && (mrsp.rd_data.susp_cnt == '0) && (age > limit_q);
    end else begin
      hit_now = mrsp.valid[cmp_idx_q] && (mrsp.rd_data.id == id_q);
    end
  end

  // short nonzero limits are raised to the minimum on write; zero is kept
  always_comb begin
    cfg_limit = TIME_W'(cfg_wdata_i);
    if ((cfg_limit != '0) && (cfg_limit < TIME_W'(MIN_LIMIT_MS))) begin
      cfg_limit = TIME_W'(MIN_LIMIT_MS);
    end
  end

  always_comb begin
    limit_d  = limit_q;
    enable_d = enable_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HANG_LIMIT:   limit_d  = cfg_limit;
        CFG_CHECK_ENABLE: enable_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    id_d         = id_q;
    now_d        = now_q;
    iss_d        = iss_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    ent_d        = ent_q;
    res_found_d  = res_found_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;

    mreq         = '0;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d       = func_e'(req_i.func);
          id_d         = req_i.client_id;
          now_d        = req_i.now_ms;
          iss_d        = '0;
          hit_d        = 1'b0;
          res_found_d  = 1'b0;
          res_id_d     = '0;
          res_status_d = ST_OK;
          case (req_i.func) inside
            FUNC_BEAT, FUNC_REMOVE, FUNC_SUSPEND, FUNC_RESUME: state_d = S_SCAN;
            FUNC_CHECK: state_d = armed ? S_SCAN : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        if (iss_q != CNT_W'(TABLE_ENTRIES)) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = iss_q[IDX_W-1:0];
          iss_d        = iss_q + CNT_W'(1);
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = iss_q[IDX_W-1:0];
        end
        if (cmp_vld_q) begin
          if (hit_now) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            ent_d     = mrsp.rd_data;
            state_d   = S_WRITE;
          end else if (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_d = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        mreq.wr_addr = hit_idx_q;
        mreq.wr_data = ent_q;
        case (func_q)
          FUNC_BEAT: begin
            if (hit_q) begin
              mreq.wr_en             = 1'b1;
              mreq.wr_data.last_beat = now_q;
            end else if (mrsp.free_found) begin
              mreq.wr_en     = 1'b1;
              mreq.set_valid = 1'b1;
              mreq.wr_addr   = mrsp.free_idx;
              mreq.wr_data   = '{id: id_q, last_beat: now_q, susp_cnt: '0};
            end else begin
              res_status_d = ST_FULL;
            end
          end
          FUNC_REMOVE: begin
            if (hit_q) begin
              mreq.clr_valid = 1'b1;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          FUNC_SUSPEND: begin
            if (!hit_q) begin
              res_status_d = ST_NOT_FOUND;
            end else if (ent_q.susp_cnt != '1) begin
              mreq.wr_en            = 1'b1;
              mreq.wr_data.susp_cnt = ent_q.susp_cnt + SCNT_W'(1);
            end
          end
          FUNC_RESUME: begin
            if (!hit_q) begin
              res_status_d = ST_NOT_FOUND;
            end else if (ent_q.susp_cnt == '0) begin
              res_status_d = ST_UNDERFLOW;
            end else begin
              mreq.wr_en            = 1'b1;
              mreq.wr_data.susp_cnt = ent_q.susp_cnt - SCNT_W'(1);
              if (ent_q.susp_cnt == SCNT_W'(1)) begin
                mreq.wr_data.last_beat = now_q;
              end
            end
          end
          FUNC_CHECK: begin
            if (hit_q) begin
              mreq.wr_en             = 1'b1;
              mreq.wr_data.last_beat = now_q;
              res_found_d            = 1'b1;
              res_id_d               = ent_q.id;
            end
          end
          default: ;
        endcase
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_id_d     = res_id_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= TIME_W'(LIMIT_RESET);
      enable_q    <= 1'b0;
      iss_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      enable_q    <= enable_d;
      iss_q       <= iss_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    id_q         <= id_d;
    now_q        <= now_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    ent_q        <= ent_d;
    res_found_q  <= res_found_d;
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
  end

endmodule

// ===== sv/mchw_checker.sv =====
// ----------------------------------------------------------------------------
// mchw_checker
// port level checks of the heartbeat watchdog, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_channel_heartbeat_watchdog_assert.svh"

module mchw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              hang_found_i,
  input logic [mchw_pkg::ID_W-1:0]         hung_id_i,
  input logic [mchw_pkg::STATUS_W-1:0]     status_i
);
  import mchw_pkg::*;

  // no response beat pending after an edge seen in reset
  `MCHW_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_ni |=> !rsp_valid_i, "response valid in reset")

  // only one request in flight
  `MCHW_ASSERT(a_one_in_flight, req_valid_i && req_ready_i |=> !req_ready_i, "second request taken")

  // hung id is zero unless a hang is reported
  `MCHW_ASSERT(a_hung_id_zero, rsp_valid_i && !hang_found_i |-> hung_id_i == '0, "stale hung id")

  // a hang report always carries an ok status
  `MCHW_ASSERT(a_hang_status_ok, rsp_valid_i && hang_found_i |-> status_i == ST_OK, "hang with error")

  // a stalled response beat holds
  `MCHW_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(hung_id_i), "response dropped")

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_mchw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .hang_found_i (rsp_o.hang_found),
  .hung_id_i    (rsp_o.hung_id),
  .status_i     (rsp_o.status)
);
